@@ rtl/core/hsv_pkg.sv @@
package hsv_pkg;

	// default number of fraction bits, 1.0 is 1 << FRAC_BITS
	localparam int FRAC_BITS_DEF = 12;

	// fixed field widths of the pixel ports
	localparam int HUE_W = 14;
	localparam int SAT_W = 13;
	localparam int OUT_W = 13;

	// six hue sectors around the color wheel
	localparam int HSV_SECTORS = 6;

	// entries in the memory of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// hue sector, named by the color at its start
	typedef enum logic [2:0] {
		SECT_RED     = 3'd0,
		SECT_YELLOW  = 3'd1,
		SECT_GREEN   = 3'd2,
		SECT_CYAN    = 3'd3,
		SECT_BLUE    = 3'd4,
		SECT_MAGENTA = 3'd5
	} hsv_sector_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} hsv_qstat_t;

endpackage

@@ rtl/core/hsv_front.sv @@
module hsv_front #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [hsv_pkg::HUE_W-1:0]    hue,
	input  logic        [hsv_pkg::SAT_W-1:0]    saturation,
	input  logic        [hsv_pkg::SAT_W-1:0]    brightness,
	input  logic                                push,
	output logic                                full,
	input  hsv_pkg::hsv_qstat_t                 q_stat,
	output logic                                q_push,
	output hsv_pkg::hsv_sector_t                sector,
	output logic        [FRAC_BITS-1:0]         frac,
	output logic        [FRAC_BITS:0]           sat,
	output logic        [FRAC_BITS:0]           val
);

	localparam int HW  = FRAC_BITS + 1;
	localparam int EW  = (FRAC_BITS + 2 > hsv_pkg::HUE_W) ? FRAC_BITS + 2 : hsv_pkg::HUE_W;
	localparam int CW  = (FRAC_BITS + 1 > hsv_pkg::SAT_W) ? FRAC_BITS + 1 : hsv_pkg::SAT_W;
	localparam int H6W = FRAC_BITS + 4;

	localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;
	localparam logic        [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam logic        [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;

	logic signed [EW-1:0]  hue_ext;
	logic                  hue_bad;
	logic [HW-1:0]         h;
	logic [CW-1:0]         sat_ext;
	logic [CW-1:0]         bri_ext;
	logic [HW-1:0]         s_d;
	logic [HW-1:0]         v_d;
	logic [H6W-1:0]        h6;
	logic [2:0]            k;
	hsv_pkg::hsv_sector_t  sector_d;
	logic                  advance;

	logic                  valid_s1;
	hsv_pkg::hsv_sector_t  sector_s1;
	logic [FRAC_BITS-1:0]  frac_s1;
	logic [HW-1:0]         sat_s1;
	logic [HW-1:0]         val_s1;

	// hue out of range is taken as 1.0, the top of the wheel
	assign hue_ext = EW'(hue);
	assign hue_bad = hue_ext[EW-1] || (hue_ext > ONE_E);
	assign h       = hue_bad ? ONE_H : hue_ext[HW-1:0];

	// saturation and value clamp to 1.0
	assign sat_ext = CW'(saturation);
	assign bri_ext = CW'(brightness);
	assign s_d     = (sat_ext > ONE_C) ? ONE_H : sat_ext[HW-1:0];
	assign v_d     = (bri_ext > ONE_C) ? ONE_H : bri_ext[HW-1:0];

	// sector and fraction from six times the hue
	assign h6 = H6W'(h) * H6W'(hsv_pkg::HSV_SECTORS);
	assign k  = h6[FRAC_BITS+2:FRAC_BITS];

	// sector six is the end of the wheel, same as sector zero
	assign sector_d = (k == 3'(hsv_pkg::HSV_SECTORS)) ? hsv_pkg::SECT_RED
		: hsv_pkg::hsv_sector_t'(k);

	assign q_push  = valid_s1 && !q_stat.full;
	assign advance = !valid_s1 || !q_stat.full;
	assign full    = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			sector_s1 <= sector_d;
			frac_s1   <= h6[FRAC_BITS-1:0];
			sat_s1    <= s_d;
			val_s1    <= v_d;
		end
	end

	assign sector = sector_s1;
	assign frac   = frac_s1;
	assign sat    = sat_s1;
	assign val    = val_s1;

endmodule

@@ rtl/core/hsv_queue.sv @@
module hsv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hsv_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     din,
	input  logic                 pop,
	output logic [WIDTH-1:0]     dout,
	output hsv_pkg::hsv_qstat_t  stat
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] dout_q;
	logic             load;

	// refill the output register from memory whenever it frees up
	assign load = (count_q != '0) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNTW'(push) - CNTW'(load);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
		if (load) begin
			dout_q <= mem[rd_ptr_q];
		end
	end

	assign dout       = dout_q;
	assign stat.full  = (count_q == CNTW'(DEPTH));
	assign stat.empty = !out_valid_q;

endmodule

@@ rtl/core/hsv_back.sv @@
module hsv_back #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hsv_pkg::hsv_qstat_t              q_stat,
	output logic                             q_pop,
	input  hsv_pkg::hsv_sector_t             sector,
	input  logic [FRAC_BITS-1:0]             frac,
	input  logic [FRAC_BITS:0]               sat,
	input  logic [FRAC_BITS:0]               val,
	input  logic                             pop,
	output logic                             empty,
	output logic [hsv_pkg::OUT_W-1:0]        red,
	output logic [hsv_pkg::OUT_W-1:0]        green,
	output logic [hsv_pkg::OUT_W-1:0]        blue
);

	localparam int HW = FRAC_BITS + 1;
	localparam int LW = 2 * FRAC_BITS + 1;
	localparam int PW = 3 * FRAC_BITS + 2;

	localparam logic [HW-1:0] ONE_H  = HW'(1) << FRAC_BITS;
	localparam logic [LW-1:0] ONE2_L = LW'(1) << (2 * FRAC_BITS);

	logic rdy_s2;
	logic rdy_s3;
	logic rdy_s4;

	// stage 2: products of saturation and fraction
	logic                  valid_s2;
	hsv_pkg::hsv_sector_t  sector_s2;
	logic [HW-1:0]         val_s2;
	logic [HW-1:0]         t_s2;
	logic [LW-1:0]         sf_s2;
	logic [LW-1:0]         sfc_s2;

	// stage 3: levels per channel
	logic                  valid_s3;
	logic [HW-1:0]         val_s3;
	logic [LW-1:0]         r_lvl_s3;
	logic [LW-1:0]         g_lvl_s3;
	logic [LW-1:0]         b_lvl_s3;

	// stage 4: scaled result
	logic                          valid_s4;
	logic [hsv_pkg::OUT_W-1:0]     red_s4;
	logic [hsv_pkg::OUT_W-1:0]     green_s4;
	logic [hsv_pkg::OUT_W-1:0]     blue_s4;

	logic [LW-1:0] t2;
	logic [LW-1:0] n2;
	logic [LW-1:0] q2;
	logic [LW-1:0] r_lvl;
	logic [LW-1:0] g_lvl;
	logic [LW-1:0] b_lvl;
	logic [PW-1:0] r_prod;
	logic [PW-1:0] g_prod;
	logic [PW-1:0] b_prod;

	assign rdy_s4 = !valid_s4 || pop;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign q_pop  = !q_stat.empty && rdy_s2;

	// zero saturation makes all three levels 1.0, so gray needs no extra path
	assign t2 = LW'(t_s2) << FRAC_BITS;
	assign n2 = ONE2_L - sf_s2;
	assign q2 = ONE2_L - sfc_s2;

	always_comb begin
		case (sector_s2)
			hsv_pkg::SECT_YELLOW: begin
				r_lvl = n2;     g_lvl = ONE2_L; b_lvl = t2;
			end
			hsv_pkg::SECT_GREEN: begin
				r_lvl = t2;     g_lvl = ONE2_L; b_lvl = q2;
			end
			hsv_pkg::SECT_CYAN: begin
				r_lvl = t2;     g_lvl = n2;     b_lvl = ONE2_L;
			end
			hsv_pkg::SECT_BLUE: begin
				r_lvl = q2;     g_lvl = t2;     b_lvl = ONE2_L;
			end
			hsv_pkg::SECT_MAGENTA: begin
				r_lvl = ONE2_L; g_lvl = t2;     b_lvl = n2;
			end
			default: begin
				r_lvl = ONE2_L; g_lvl = q2;     b_lvl = t2;
			end
		endcase
	end

	assign r_prod = PW'(val_s3) * PW'(r_lvl_s3);
	assign g_prod = PW'(val_s3) * PW'(g_lvl_s3);
	assign b_prod = PW'(val_s3) * PW'(b_lvl_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= q_pop;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sector_s2 <= sector;
			val_s2    <= val;
			t_s2      <= ONE_H - sat;
			sf_s2     <= LW'(sat) * LW'(frac);
			sfc_s2    <= LW'(sat) * LW'(ONE_H - HW'(frac));
		end
		if (rdy_s3 && valid_s2) begin
			val_s3   <= val_s2;
			r_lvl_s3 <= r_lvl;
			g_lvl_s3 <= g_lvl;
			b_lvl_s3 <= b_lvl;
		end
		if (rdy_s4 && valid_s3) begin
			red_s4   <= hsv_pkg::OUT_W'(r_prod >> (2 * FRAC_BITS));
			green_s4 <= hsv_pkg::OUT_W'(g_prod >> (2 * FRAC_BITS));
			blue_s4  <= hsv_pkg::OUT_W'(b_prod >> (2 * FRAC_BITS));
		end
	end

	assign empty = !valid_s4;
	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
// hsv to rgb pixel converter
// input side is a queue write port: a pixel (hue, saturation, brightness)
//   transfers on a clock edge with push high and full low
// output side is a queue read port: the oldest rgb result sits on
//   red, green, blue while empty is low and transfers with pop high
// all values are fixed point with FRAC_BITS fraction bits, 1 << FRAC_BITS is 1.0
// hue outside 0..1.0 is taken as 1.0, saturation and brightness clamp to 1.0
// on its way a result passes through the front register, the queue
//   memory, the queue read register, two back stages and the output
//   register
// throughput: one pixel per cycle while pop stays high; the last back
//   stage has one brightness times level multiplier per channel
// a stalled output fills the back pipeline, then the queue, then the
//   front register; full rises only once all of those hold a pixel
// reset clears every valid flag: after arst_n falls the block is empty
//   and not full, pixels in flight are dropped
// full and empty come straight from registers, so no combinational
//   path runs from push to full or from pop to empty
module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [hsv_pkg::HUE_W-1:0] hue,
	input  logic        [hsv_pkg::SAT_W-1:0] saturation,
	input  logic        [hsv_pkg::SAT_W-1:0] brightness,
	output logic                             empty,
	input  logic                             pop,
	output logic        [hsv_pkg::OUT_W-1:0] red,
	output logic        [hsv_pkg::OUT_W-1:0] green,
	output logic        [hsv_pkg::OUT_W-1:0] blue
);

	// queue entry: sector, fraction, saturation, value
	localparam int QW = 3 + FRAC_BITS + 2 * (FRAC_BITS + 1);

	// 1.0 on the output fields, only meaningful while it fits in them
	localparam logic [hsv_pkg::OUT_W-1:0] OUT_ONE = hsv_pkg::OUT_W'(1 << FRAC_BITS);

	hsv_pkg::hsv_qstat_t   q_stat;
	logic                  q_push;
	logic                  q_pop;
	logic [QW-1:0]         q_din;
	logic [QW-1:0]         q_dout;

	hsv_pkg::hsv_sector_t  f_sector;
	logic [FRAC_BITS-1:0]  f_frac;
	logic [FRAC_BITS:0]    f_sat;
	logic [FRAC_BITS:0]    f_val;

	hsv_pkg::hsv_sector_t  b_sector;
	logic [FRAC_BITS-1:0]  b_frac;
	logic [FRAC_BITS:0]    b_sat;
	logic [FRAC_BITS:0]    b_val;

	// front: clamps and splits the hue into sector and fraction
	hsv_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.push       (push),
		.full       (full),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.sector     (f_sector),
		.frac       (f_frac),
		.sat        (f_sat),
		.val        (f_val)
	);

	assign q_din = {f_sector, f_frac, f_sat, f_val};

	// short queue lets the front keep taking pixels while the back stalls
	hsv_queue #(
		.WIDTH (QW),
		.DEPTH (hsv_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.stat   (q_stat)
	);

	assign b_sector = hsv_pkg::hsv_sector_t'(q_dout[QW-1 -: 3]);
	assign b_frac   = q_dout[2*(FRAC_BITS+1) +: FRAC_BITS];
	assign b_sat    = q_dout[FRAC_BITS+1 +: FRAC_BITS+1];
	assign b_val    = q_dout[FRAC_BITS:0];

	// back: builds the channel levels and scales them by the value
	hsv_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.sector (b_sector),
		.frac   (b_frac),
		.sat    (b_sat),
		.val    (b_val),
		.pop    (pop),
		.empty  (empty),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	// back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	// every channel stays within 1.0 while 1.0 fits in the output fields
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (FRAC_BITS > 12) || (red <= OUT_ONE && green <= OUT_ONE
			&& blue <= OUT_ONE))
		else $error("result channel above 1.0");

endmodule

@@ tb/hsv_to_rgb_converter_tb.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

	localparam int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF;
	localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;        // 1.0
	localparam longint unsigned UNIT_SQ = UNIT * UNIT;           // 1.0 at double precision
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;                            // extra wait for strays after the last owed color

	typedef struct packed {
		logic [hsv_pkg::OUT_W-1:0] red;
		logic [hsv_pkg::OUT_W-1:0] green;
		logic [hsv_pkg::OUT_W-1:0] blue;
	} rgb_pixel_t;

	// block ports, the driven inputs all known from time zero
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             push = 1'b0;
	logic                             full;
	logic signed [hsv_pkg::HUE_W-1:0] hue = '0;
	logic        [hsv_pkg::SAT_W-1:0] saturation = '0;
	logic        [hsv_pkg::SAT_W-1:0] brightness = '0;
	logic                             empty;
	logic                             pop = 1'b0;
	logic        [hsv_pkg::OUT_W-1:0] red;
	logic        [hsv_pkg::OUT_W-1:0] green;
	logic        [hsv_pkg::OUT_W-1:0] blue;

	// colors still owed by the block, oldest first
	rgb_pixel_t rgb_owed[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         bursts_on = 1'b1;   // random idle bursts on both sides
	int         pop_hold_left = 0;  // long receiver hold-off, counted down below

	hsv_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter_tb failed");
			$finish;
		end
	end

	// one channel: value times a double-precision level, truncated, kept to 13 bits
	function automatic logic [hsv_pkg::OUT_W-1:0] scaled_channel(
			input longint unsigned val, input longint unsigned level);
		longint unsigned prod;
		prod = (val * level) >> (2 * FRAC_BITS);
		return prod[hsv_pkg::OUT_W-1:0];
	endfunction

	// expected color for one pixel
	function automatic rgb_pixel_t rgb_from_hsv(
			input logic signed [hsv_pkg::HUE_W-1:0] h_in,
			input logic [hsv_pkg::SAT_W-1:0] s_in, input logic [hsv_pkg::SAT_W-1:0] v_in);
		int                   h_int;
		longint unsigned      h_fix, s_fix, v_fix, h_six, sect_num, frac;
		longint unsigned      lvl_t, lvl_n, lvl_q, lvl_r, lvl_g, lvl_b;
		hsv_pkg::hsv_sector_t sect;
		rgb_pixel_t           px;
		h_int = int'(h_in);
		// hue outside 0..1.0 becomes 1.0
		if (h_int < 0 || h_int > int'(UNIT))
			h_fix = UNIT;
		else
			h_fix = longint'(h_int);
		// oversized saturation and brightness clamp to 1.0
		s_fix = (s_in > UNIT) ? UNIT : longint'(s_in);
		v_fix = (v_in > UNIT) ? UNIT : longint'(v_in);
		// no saturation: gray at the brightness level
		if (s_fix == 0) begin
			px.red = v_fix[hsv_pkg::OUT_W-1:0];
			px.green = v_fix[hsv_pkg::OUT_W-1:0];
			px.blue = v_fix[hsv_pkg::OUT_W-1:0];
			return px;
		end
		h_six = h_fix * hsv_pkg::HSV_SECTORS;
		sect_num = h_six >> FRAC_BITS;
		frac = h_six & (UNIT - 1);
		// hue of exactly 1.0 lands in sector six, which wraps to red
		if (sect_num >= hsv_pkg::HSV_SECTORS)
			sect = hsv_pkg::SECT_RED;
		else
			sect = hsv_pkg::hsv_sector_t'(sect_num[2:0]);
		lvl_t = (UNIT - s_fix) * UNIT;
		lvl_n = UNIT_SQ - s_fix * frac;
		lvl_q = UNIT_SQ - s_fix * (UNIT - frac);
		case (sect)
			hsv_pkg::SECT_YELLOW: begin
				lvl_r = lvl_n;   lvl_g = UNIT_SQ; lvl_b = lvl_t;
			end
			hsv_pkg::SECT_GREEN: begin
				lvl_r = lvl_t;   lvl_g = UNIT_SQ; lvl_b = lvl_q;
			end
			hsv_pkg::SECT_CYAN: begin
				lvl_r = lvl_t;   lvl_g = lvl_n;   lvl_b = UNIT_SQ;
			end
			hsv_pkg::SECT_BLUE: begin
				lvl_r = lvl_q;   lvl_g = lvl_t;   lvl_b = UNIT_SQ;
			end
			hsv_pkg::SECT_MAGENTA: begin
				lvl_r = UNIT_SQ; lvl_g = lvl_t;   lvl_b = lvl_n;
			end
			default: begin
				lvl_r = UNIT_SQ; lvl_g = lvl_q;   lvl_b = lvl_t;
			end
		endcase
		px.red = scaled_channel(v_fix, lvl_r);
		px.green = scaled_channel(v_fix, lvl_g);
		px.blue = scaled_channel(v_fix, lvl_b);
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// offer one pixel and hold it until the block takes it
	// push stays high afterwards so back-to-back transfers need no gap
	task automatic send_pixel(input logic signed [hsv_pkg::HUE_W-1:0] h,
			input logic [hsv_pkg::SAT_W-1:0] s, input logic [hsv_pkg::SAT_W-1:0] v);
		int gap;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			push <= 1'b0;
			// junk on the fields while idle must be ignored
			hue <= hsv_pkg::HUE_W'($urandom);
			saturation <= hsv_pkg::SAT_W'($urandom);
			brightness <= hsv_pkg::SAT_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (full);
		rgb_owed.push_back(rgb_from_hsv(h, s, v));
	endtask

	task automatic stop_sending();
		push <= 1'b0;
	endtask

	// mostly in-range pixels, a few with raw full-width fields
	task automatic send_random_pixel();
		logic signed [hsv_pkg::HUE_W-1:0] h;
		logic        [hsv_pkg::SAT_W-1:0] s;
		logic        [hsv_pkg::SAT_W-1:0] v;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			h = hsv_pkg::HUE_W'($urandom_range(0, int'(UNIT)));
			s = hsv_pkg::SAT_W'($urandom_range(0, int'(UNIT)));
			v = hsv_pkg::SAT_W'($urandom_range(0, int'(UNIT)));
			// lean on the corners now and then
			if ($urandom_range(0, 9) == 0)
				s = $urandom_range(0, 1) ? '0 : hsv_pkg::SAT_W'(UNIT);
			if ($urandom_range(0, 9) == 0)
				v = $urandom_range(0, 1) ? '0 : hsv_pkg::SAT_W'(UNIT);
		end else begin
			h = hsv_pkg::HUE_W'($urandom);
			s = hsv_pkg::SAT_W'($urandom);
			v = hsv_pkg::SAT_W'($urandom);
		end
		send_pixel(h, s, v);
	endtask

	// extremes of every field, including out-of-range hue and oversized levels
	task automatic test_field_extremes();
		send_pixel(-14'sd8192, 13'd4096, 13'd4096);
		send_pixel(14'sd8191, 13'd4096, 13'd4096);
		send_pixel(-14'sd1, 13'd2048, 13'd4096);
		send_pixel(14'sd0, 13'd4096, 13'd4096);
		send_pixel(14'sd4096, 13'd4096, 13'd4096);
		send_pixel(14'sd4097, 13'd1, 13'd4096);
		send_pixel(14'sd1000, 13'd8191, 13'd8191);
		send_pixel(14'sd2000, 13'd4097, 13'd0);
		send_pixel(14'sd3000, 13'd1, 13'd1);
	endtask

	// one pixel in each sector, plus the sector edges
	task automatic test_each_sector();
		send_pixel(14'sd300, 13'd3000, 13'd4000);
		send_pixel(14'sd682, 13'd4096, 13'd4096);
		send_pixel(14'sd683, 13'd4096, 13'd4096);
		send_pixel(14'sd1000, 13'd3000, 13'd4000);
		send_pixel(14'sd1700, 13'd3000, 13'd4000);
		send_pixel(14'sd2400, 13'd3000, 13'd4000);
		send_pixel(14'sd3100, 13'd3000, 13'd4000);
		send_pixel(14'sd3800, 13'd3000, 13'd4000);
		send_pixel(14'sd4095, 13'd4096, 13'd4096);
	endtask

	// zero saturation gives gray, whatever the hue
	task automatic test_gray();
		send_pixel(14'sd1234, 13'd0, 13'd4096);
		send_pixel(-14'sd77, 13'd0, 13'd2345);
		send_pixel(14'sd4096, 13'd0, 13'd8191);
		send_pixel(14'sd500, 13'd0, 13'd0);
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n) send_random_pixel();
	endtask

	// receiver holds off long enough for the block to fill and raise full
	task automatic test_output_backpressure();
		pop_hold_left = 300;
		repeat (60) send_random_pixel();
	endtask

	// last part: both sides run flat out
	task automatic test_full_rate();
		bursts_on = 1'b0;
		repeat (80) send_random_pixel();
	endtask

	// receiver: long hold-off first, then random stall bursts, else always pop
	initial begin : drive_pop
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (pop_hold_left > 0) begin
				pop <= 1'b0;
				pop_hold_left--;
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// every color transfer is compared with the oldest owed color
	always @(posedge clk) begin : check_rgb
		rgb_pixel_t want;
		if (arst_n && pop && !empty) begin
			if (rgb_owed.size() == 0) begin
				report_mismatch("unexpected color transfer, red", int'(red), 0);
			end else begin
				want = rgb_owed.pop_front();
				if (red !== want.red)
					report_mismatch("red", int'(red), int'(want.red));
				if (green !== want.green)
					report_mismatch("green", int'(green), int'(want.green));
				if (blue !== want.blue)
					report_mismatch("blue", int'(blue), int'(want.blue));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_each_sector();
		test_gray();
		test_random_traffic(450);
		test_output_backpressure();
		test_full_rate();
		stop_sending();

		// drain whatever is still in flight, then watch for strays
		while (rgb_owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && rgb_owed.size() == 0)
			$display("hsv_to_rgb_converter_tb passed");
		else
			$display("hsv_to_rgb_converter_tb failed");
		$finish;
	end

endmodule
